### src/dsvrp_pkg.sv
// dsvrp_pkg: shared types and constants for the delimiter-separated row parser.
// Holds the result kinds, the parse modes and the special byte codes.
// No dependencies.
package dsvrp_pkg;

  localparam logic [7:0] BYTE_NL    = 8'd10;
  localparam logic [7:0] BYTE_QUOTE = 8'd34;
  localparam logic [7:0] BYTE_COMMA = 8'd44;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_FIELD  = 2'd1,
    KIND_ROW    = 2'd2,
    KIND_STREAM = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_OUT        = 2'd0,
    MODE_IN         = 2'd1,
    MODE_QUOTE_SEEN = 2'd2,
    MODE_DONE       = 2'd3
  } mode_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
  } result_t;

endpackage

### src/dsv_row_parser.sv
// dsv_row_parser: byte-serial parser for delimiter-separated text with quoting.
// Depends on dsvrp_pkg for result kinds, parse modes and byte codes.
//
// The block takes one text byte per transaction on the slave stream (tlast marks
// end of input; its data byte is ignored) and turns it into zero to three result
// transactions on the master stream: field characters, end of field, end of row
// and end of stream, tuser giving the kind. A quote outside quotes opens quoted
// mode; inside quotes the delimiter and newline are literal and a doubled quote
// yields one quote character; a quote followed by any other byte closes quoting
// and that byte is parsed as unquoted. A newline ends the row (an empty line gives
// a row with no fields). End of input closes a non-empty partial row, then sends
// end of stream; every later transaction is swallowed without results. A byte
// waits in the input register and is parsed on its way into the result buffer.
// The input side takes one byte per cycle as long as each byte yields at most one
// result and the master side is ready; the result buffer drains one result per
// cycle while tready is high, so a byte that yields two or three results (newline,
// end of input) holds the input side until its last result is being taken. While
// a result waits on the master side, the input register still takes one byte,
// then holds it and drops tready until the result buffer frees up. The delimiter
// register is written through the cfg channel, which is always ready; write it
// only while the block is idle. A delimiter of quote acts as comma.
module dsv_row_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration: delimiter byte
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  // Input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,    // [7:0] data_byte
  input  logic       s_axis_tlast_i,    // end_of_input
  // Result stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,    // [7:0] field_char
  output logic [1:0] m_axis_tuser_o,    // [1:0] kind
  output logic       m_axis_tlast_o     // last result of this input byte
);
  import dsvrp_pkg::*;

  // Configuration and parse state
  logic [7:0] delim_q;
  mode_e      mode_q, mode_d;
  logic       fhc_q, fhc_d;   // current field holds characters
  logic       rhf_q, rhf_d;   // current row has finished fields

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_eoi_q;

  // Result buffer: entry 0 is presented on the master side
  result_t    res_q [MaxResults];
  result_t    res_d [MaxResults];
  logic [CntW-1:0] cnt_q, cnt_d;

  // Parser outputs
  result_t    par_res [MaxResults];
  logic [CntW-1:0] par_cnt;

  logic [7:0] sep;
  logic       s_accept, pop, buf_free, load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= BYTE_COMMA;
    end else if (cfg_valid_i && cfg_ready_o) begin
      delim_q <= cfg_data_i;
    end
  end

  // Handshake control
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign buf_free        = (cnt_q == '0) || ((cnt_q == CntW'(1)) && m_axis_tready_i);
  assign load            = in_valid_q && buf_free;
  assign s_axis_tready_o = !in_valid_q || load;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tlast_i;
    end
  end

  // Parse one byte: results and next state
  assign sep = (delim_q == BYTE_QUOTE) ? BYTE_COMMA : delim_q;

  always_comb begin
    logic unquoted;
    logic used;
    unquoted = 1'b0;
    used     = fhc_q || rhf_q;
    mode_d   = mode_q;
    fhc_d    = fhc_q;
    rhf_d    = rhf_q;
    par_cnt  = '0;
    for (int i = 0; i < MaxResults; i++) begin
      par_res[i] = '{kind: KIND_CHAR, ch: 8'd0};
    end

    if (mode_q == MODE_DONE) begin
      par_cnt = '0;
    end else if (in_eoi_q) begin
      // Close a partial row, then end the stream
      if (used) begin
        par_res[0].kind = KIND_FIELD;
        par_res[1].kind = KIND_ROW;
        par_res[2].kind = KIND_STREAM;
        par_cnt         = CntW'(3);
      end else begin
        par_res[0].kind = KIND_STREAM;
        par_cnt         = CntW'(1);
      end
      mode_d = MODE_DONE;
      fhc_d  = 1'b0;
      rhf_d  = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_IN: begin
          if (in_byte_q == BYTE_QUOTE) begin
            mode_d = MODE_QUOTE_SEEN;
          end else begin
            par_res[0] = '{kind: KIND_CHAR, ch: in_byte_q};
            par_cnt    = CntW'(1);
            fhc_d      = 1'b1;
          end
        end
        MODE_QUOTE_SEEN: begin
          if (in_byte_q == BYTE_QUOTE) begin
            // Doubled quote: literal quote, stay quoted
            par_res[0] = '{kind: KIND_CHAR, ch: BYTE_QUOTE};
            par_cnt    = CntW'(1);
            fhc_d      = 1'b1;
            mode_d     = MODE_IN;
          end else begin
            mode_d   = MODE_OUT;
            unquoted = 1'b1;
          end
        end
        default: begin
          unquoted = 1'b1;
        end
      endcase

      if (unquoted) begin
        if (in_byte_q == BYTE_NL) begin
          if (used) begin
            par_res[0].kind = KIND_FIELD;
            par_res[1].kind = KIND_ROW;
            par_cnt         = CntW'(2);
          end else begin
            par_res[0].kind = KIND_ROW;
            par_cnt         = CntW'(1);
          end
          fhc_d = 1'b0;
          rhf_d = 1'b0;
        end else if (in_byte_q == sep) begin
          par_res[0].kind = KIND_FIELD;
          par_cnt         = CntW'(1);
          rhf_d           = 1'b1;
          fhc_d           = 1'b0;
        end else if (in_byte_q == BYTE_QUOTE) begin
          mode_d = MODE_IN;
        end else begin
          par_res[0] = '{kind: KIND_CHAR, ch: in_byte_q};
          par_cnt    = CntW'(1);
          fhc_d      = 1'b1;
        end
      end
    end
  end

  // Advance parse state only when the byte moves into the result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OUT;
      fhc_q  <= 1'b0;
      rhf_q  <= 1'b0;
    end else if (load) begin
      mode_q <= mode_d;
      fhc_q  <= fhc_d;
      rhf_q  <= rhf_d;
    end
  end

  // Result buffer: shift out on pop, reload from the parser when free
  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
      cnt_d = cnt_q - CntW'(1);
    end
    if (load) begin
      res_d = par_res;
      cnt_d = par_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = res_q[0].ch;
  assign m_axis_tuser_o  = res_q[0].kind;
  assign m_axis_tlast_o  = (cnt_q == CntW'(1));

  // Checks
  a_char_is_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == KIND_CHAR)) |-> m_axis_tlast_o)
    else $error("field character not marked as last result of its byte");

  a_stream_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == KIND_STREAM)) |-> m_axis_tlast_o)
    else $error("end of stream not marked as last result");

  a_done_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_DONE) |=> (mode_q == MODE_DONE))
    else $error("parser left the stream-ended mode");

  a_no_result_after_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (mode_q == MODE_DONE)) |=> (cnt_q == '0))
    else $error("results produced after end of stream");

  a_char_zero_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != KIND_CHAR)) |-> (m_axis_tdata_o == 8'd0))
    else $error("marker result carries nonzero character");

endmodule
